FILE: rtl/rfps_pkg.sv
// Shared types and constants for the radar frame parser and smoother.
`default_nettype none

package rfps_pkg;

  // Frame geometry
  localparam int unsigned FRAME_LEN = 18;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned IDX_W     = $clog2(FRAME_LEN);
  localparam logic [POS_W:0] FRAME_LEN_C = (POS_W + 1)'(FRAME_LEN);

  // Header sequence
  localparam logic [7:0] HDR_BYTE0 = 8'hF4;
  localparam logic [7:0] HDR_BYTE1 = 8'hF3;
  localparam logic [7:0] HDR_BYTE2 = 8'hF2;
  localparam logic [7:0] HDR_BYTE3 = 8'hF1;

  // Frame layout
  localparam int unsigned OFS_TYPE       = 6;
  localparam int unsigned OFS_STATUS     = 8;
  localparam int unsigned OFS_MOV_DIST   = 9;
  localparam int unsigned OFS_MOV_ENERGY = 11;
  localparam int unsigned OFS_STA_DIST   = 13;
  localparam int unsigned OFS_STA_ENERGY = 15;

  localparam logic [7:0] TYPE_TARGET = 8'h02;
  localparam logic [1:0] STAT_MOVING = 2'h1;
  localparam logic [1:0] STAT_STATIC = 2'h2;

  // Distances
  localparam logic [15:0] DIST_IDLE   = 16'd999;
  localparam logic [15:0] DIST_NONE   = 16'd0;

  // Smoothing: (7 * old + 3 * new) / 10, divide by reciprocal multiply
  localparam int unsigned SUM_W       = 20;
  localparam logic [SUM_W-1:0] W_OLD  = 20'd7;
  localparam logic [SUM_W-1:0] W_NEW  = 20'd3;
  localparam logic [SUM_W-1:0] RECIP10 = 20'd838861;
  localparam int unsigned RECIP_SHIFT = 23;

  // Configuration
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_ENERGY = 1'b0,
    CFG_MAX_RANGE  = 1'b1
  } cfg_idx_e;

  localparam logic [7:0]  MIN_ENERGY_RST = 8'd8;
  localparam logic [15:0] MAX_RANGE_RST  = 16'd250;

  // Completed frame as seen by the evaluator
  typedef struct packed {
    logic        done;
    logic [7:0]  ftype;
    logic [1:0]  status;
    logic [15:0] mov_dist;
    logic [7:0]  mov_energy;
    logic [15:0] sta_dist;
    logic [7:0]  sta_energy;
  } frame_t;

  typedef struct packed {
    logic        detected;
    logic [15:0] raw_distance;
    logic [15:0] smoothed_distance;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/radar_frame_parser_smoother.sv
// Top level: radar UART frame parser with gated, smoothed distance output.
// Path: an accepted byte is held in the input register, which feeds the
//   collector; a frame's result word is registered as its last byte leaves it.
// Throughput: one byte word per cycle, set by the single input register
//   and single-pass update; stalls only when a result is due and one waits.
// Reset (rst_ni low, async): header search restarts, flag 0, distances 999,
//   min_energy 8, max_range 250; captured frame bytes are not cleared.
`default_nettype none

module radar_frame_parser_smoother (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // byte input channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [7:0]                     rx_byte_i,
  // result channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                detected_o,
  output logic [15:0]                         raw_distance_o,
  output logic [15:0]                         smoothed_distance_o,
  // configuration write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [rfps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [rfps_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rfps_pkg::*;

  // Configuration registers
  logic [7:0]  min_energy_q;
  logic [15:0] max_range_q;

  // Input register
  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  s1_byte_q;

  // Result register
  logic        out_valid_q, out_valid_d;
  result_t     out_q;

  logic        advance;
  logic        last;
  logic        out_free;
  frame_t      frame;
  result_t     result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_energy_q <= MIN_ENERGY_RST;
      max_range_q  <= MAX_RANGE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_ENERGY: min_energy_q <= cfg_data_i[7:0];
        CFG_MAX_RANGE:  max_range_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // The held byte moves on unless it closes a frame while the result
  // register is still occupied and stalled.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && (!last || out_free);
  assign in_stall_o = s1_valid_q && !advance;

  assign s1_valid_d = in_stall_o ? s1_valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      s1_byte_q <= rx_byte_i;
    end
  end

  rfps_collector u_collector (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (s1_byte_q),
    .last_o    (last),
    .frame_o   (frame)
  );

  rfps_evaluator u_evaluator (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_i      (frame),
    .min_energy_i (min_energy_q),
    .max_range_i  (max_range_q),
    .result_o     (result)
  );

  // Every completed frame gives one result word, whatever its type
  always_comb begin
    out_valid_d = out_valid_q;
    if (frame.done) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame.done) begin
      out_q <= result;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign detected_o          = out_q.detected;
  assign raw_distance_o      = out_q.raw_distance;
  assign smoothed_distance_o = out_q.smoothed_distance;

endmodule

`default_nettype wire

FILE: rtl/rfps_collector.sv
// Header search and frame byte capture.
`default_nettype none

module rfps_collector (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          advance_i,
  input  wire logic [7:0]    byte_i,
  output logic               last_o,
  output rfps_pkg::frame_t   frame_o
);
  import rfps_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d, pos_inc;
  logic [7:0]       frame_q [FRAME_LEN];
  logic [7:0]       cur     [FRAME_LEN];
  logic             hdr_ok;
  logic             in_frame;

  always_comb begin
    case (pos_q)
      POS_W'(0): hdr_ok = (byte_i == HDR_BYTE0);
      POS_W'(1): hdr_ok = (byte_i == HDR_BYTE1);
      POS_W'(2): hdr_ok = (byte_i == HDR_BYTE2);
      POS_W'(3): hdr_ok = (byte_i == HDR_BYTE3);
      default:   hdr_ok = 1'b1;
    endcase
  end

  assign pos_inc  = pos_q + 1'b1;
  assign last_o   = ({1'b0, pos_inc} >= FRAME_LEN_C);
  assign in_frame = ({1'b0, pos_q} < FRAME_LEN_C);

  always_comb begin
    pos_d = pos_q;
    if (advance_i) begin
      if (!hdr_ok || last_o) begin
        pos_d = '0;
      end else begin
        pos_d = pos_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && hdr_ok && in_frame) begin
      frame_q[pos_q[IDX_W-1:0]] <= byte_i;
    end
  end

  // Current byte bypasses storage so a field may sit in the final byte
  always_comb begin
    for (int k = 0; k < FRAME_LEN; k++) begin
      cur[k] = (pos_q == POS_W'(k)) ? byte_i : frame_q[k];
    end
  end

  always_comb begin
    frame_o.done       = advance_i && hdr_ok && last_o;
    frame_o.ftype      = cur[OFS_TYPE];
    frame_o.status     = cur[OFS_STATUS][1:0];
    frame_o.mov_dist   = {cur[OFS_MOV_DIST + 1], cur[OFS_MOV_DIST]};
    frame_o.mov_energy = cur[OFS_MOV_ENERGY];
    frame_o.sta_dist   = {cur[OFS_STA_DIST + 1], cur[OFS_STA_DIST]};
    frame_o.sta_energy = cur[OFS_STA_ENERGY];
  end

endmodule

`default_nettype wire

FILE: rtl/rfps_evaluator.sv
// Target selection, gating and distance smoothing.
`default_nettype none

module rfps_evaluator (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  rfps_pkg::frame_t      frame_i,
  input  wire logic [7:0]       min_energy_i,
  input  wire logic [15:0]      max_range_i,
  output rfps_pkg::result_t     result_o
);
  import rfps_pkg::*;

  logic        detect_q, detect_d;
  logic [15:0] dist_q, dist_d;
  logic [15:0] smooth_q, smooth_d;

  logic [15:0]          sel_dist;
  logic [7:0]           sel_energy;
  logic                 pass;
  logic [SUM_W-1:0]     sum;
  logic [2*SUM_W-1:0]   prod;

  always_comb begin
    sel_dist   = DIST_IDLE;
    sel_energy = 8'd0;
    if ((frame_i.status & STAT_MOVING) != 2'd0) begin
      sel_dist   = frame_i.mov_dist;
      sel_energy = frame_i.mov_energy;
    end else if ((frame_i.status & STAT_STATIC) != 2'd0) begin
      sel_dist   = frame_i.sta_dist;
      sel_energy = frame_i.sta_energy;
    end
  end

  assign pass = (sel_dist != 16'd0) && (sel_dist <= max_range_i) &&
                (sel_energy > min_energy_i);

  // Sum stays below 2^20, where the reciprocal gives an exact quotient
  assign sum  = SUM_W'(smooth_q) * W_OLD + SUM_W'(sel_dist) * W_NEW;
  assign prod = (2*SUM_W)'(sum) * (2*SUM_W)'(RECIP10);

  always_comb begin
    detect_d = detect_q;
    dist_d   = dist_q;
    smooth_d = smooth_q;
    if (frame_i.done && frame_i.ftype == TYPE_TARGET) begin
      if (pass) begin
        detect_d = 1'b1;
        dist_d   = sel_dist;
        smooth_d = prod[RECIP_SHIFT +: 16];
      end else begin
        detect_d = 1'b0;
        dist_d   = DIST_NONE;
        smooth_d = DIST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detect_q <= 1'b0;
      dist_q   <= DIST_IDLE;
      smooth_q <= DIST_IDLE;
    end else begin
      detect_q <= detect_d;
      dist_q   <= dist_d;
      smooth_q <= smooth_d;
    end
  end

  assign result_o = '{detected: detect_d, raw_distance: dist_d,
                      smoothed_distance: smooth_d};

endmodule

`default_nettype wire

FILE: rtl/rfps_checker.sv
// Port-level checker for the radar frame parser, bound to the top level.
`default_nettype none

module rfps_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_stall_o,
  input wire logic [7:0]                      rx_byte_i,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire logic                            detected_o,
  input wire logic [15:0]                     raw_distance_o,
  input wire logic [15:0]                     smoothed_distance_o,
  input wire logic                            cfg_valid_i,
  input wire logic                            cfg_ready_o,
  input wire logic [rfps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input wire logic [rfps_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rfps_pkg::*;

  // A waiting result word stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(detected_o) &&
      $stable(raw_distance_o) && $stable(smoothed_distance_o))
    else $error("stalled result word changed");

  // Input backpressure only comes from a blocked result word
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with result side free");

  // No detection always reports the idle smoothed distance
  a_idle_smooth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !detected_o |-> smoothed_distance_o == DIST_IDLE)
    else $error("smoothed distance not idle without detection");

  a_det_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && detected_o |-> raw_distance_o != DIST_NONE)
    else $error("detection with zero distance");

endmodule

bind radar_frame_parser_smoother rfps_checker u_rfps_checker (.*);

`default_nettype wire
